/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Each check is sampled on the rising clock edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCFE_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCFE_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fcfe_pkg.sv */
package fcfe_pkg;

    localparam int POS_W = 17;

    localparam logic [7:0]       HEAD_MARK        = 8'h68;
    localparam logic [7:0]       TAIL_MARK        = 8'h16;
    localparam logic [POS_W-1:0] POS_MAX          = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_LEN_LO       = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI       = 17'd2;
    localparam logic [POS_W-1:0] POS_TYPE         = 17'd3;
    localparam logic [POS_W-1:0] POS_CMD_FIRST    = 17'd4;
    localparam logic [POS_W-1:0] POS_CMD_LAST     = 17'd7;
    localparam logic [POS_W-1:0] POS_ADDR_FIRST   = 17'd8;
    localparam logic [POS_W-1:0] POS_ADDR_LAST    = 17'd13;
    localparam logic [POS_W-1:0] POS_SECOND_START = 17'd18;
    localparam logic [POS_W-1:0] PAYLOAD_START    = 17'd19;
    // Shortest legal message; also the header plus trailer overhead.
    localparam logic [POS_W:0]   MIN_LEN          = 18'd21;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_HEAD_TAIL    = 3'd2,
        ST_LENGTH       = 3'd3,
        ST_SECOND_START = 3'd4,
        ST_CHECKSUM     = 3'd5
    } check_status_t;

    typedef enum logic {
        REC_PAYLOAD = 1'b0,
        REC_END     = 1'b1
    } record_kind_t;

    // One received byte.
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } fcfe_item_t;

    // One outgoing record.
    typedef struct packed {
        record_kind_t  kind;
        logic [7:0]    payload_byte;
        logic [15:0]   payload_index;
        check_status_t check_status;
        logic [2:0]    frame_type;
        logic          status_flag;
        logic          ack_flag;
        logic [31:0]   command_word;
        logic [47:0]   device_address;
        logic [15:0]   payload_length;
    } fcfe_result_t;

endpackage

/* sv/fcfe_core.sv */
`include "assert_macros.svh"

module fcfe_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  fcfe_pkg::fcfe_item_t   item,
    output logic                   has_result,
    output fcfe_pkg::fcfe_result_t result
);
    import fcfe_pkg::*;

    pos_t            pos_reg,      pos_next;
    logic [7:0]      sum_reg,      sum_next;
    logic [7:0]      prev_reg,     prev_next;
    logic            head_ok_reg,  head_ok_next;
    logic            second_ok_reg, second_ok_next;
    logic [15:0]     len_reg,      len_next;
    logic [7:0]      type_reg,     type_next;
    logic [3:0][7:0] cmd_reg,      cmd_next;
    logic [5:0][7:0] addr_reg,     addr_next;

    logic [POS_W:0]  msg_len;
    logic [POS_W:0]  expect_len;
    pos_t            pay_rel;
    logic            in_payload;
    check_status_t   status;

    // Derived comparisons on the current position
    assign msg_len    = {1'b0, pos_reg} + 18'd1;
    assign expect_len = {2'b00, len_reg} + MIN_LEN;
    assign pay_rel    = pos_reg - PAYLOAD_START;
    assign in_payload = (pos_reg >= PAYLOAD_START) && (pay_rel < {1'b0, len_reg});

    // Check precedence on the final byte
    always_comb begin
        if (msg_len < MIN_LEN) begin
            status = ST_SHORT;
        end else if (!head_ok_reg || item.data != TAIL_MARK) begin
            status = ST_HEAD_TAIL;
        end else if (expect_len != msg_len) begin
            status = ST_LENGTH;
        end else if (!second_ok_reg) begin
            status = ST_SECOND_START;
        end else if (sum_reg != prev_reg) begin
            status = ST_CHECKSUM;
        end else begin
            status = ST_OK;
        end
    end

    // Build the record for the byte in hand
    always_comb begin
        result     = '0;
        has_result = 1'b0;
        if (item.last) begin
            has_result          = 1'b1;
            result.kind         = REC_END;
            result.check_status = status;
            if (status == ST_OK) begin
                result.frame_type     = type_reg[2:0];
                result.status_flag    = type_reg[6];
                result.ack_flag       = type_reg[7];
                result.command_word   = cmd_reg;
                result.device_address = addr_reg;
                result.payload_length = len_reg;
            end
        end else if (in_payload) begin
            has_result           = 1'b1;
            result.kind          = REC_PAYLOAD;
            result.payload_byte  = item.data;
            result.payload_index = pay_rel[15:0];
        end
    end

    // Advance the message state by one byte, clear it after the final byte
    always_comb begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        prev_next      = prev_reg;
        head_ok_next   = head_ok_reg;
        second_ok_next = second_ok_reg;
        len_next       = len_reg;
        type_next      = type_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        if (step) begin
            if (item.last) begin
                pos_next       = '0;
                sum_next       = '0;
                prev_next      = '0;
                head_ok_next   = 1'b0;
                second_ok_next = 1'b0;
                len_next       = '0;
                type_next      = '0;
                cmd_next       = '0;
                addr_next      = '0;
            end else begin
                if (pos_reg == '0) begin
                    head_ok_next = (item.data == HEAD_MARK);
                end else if (pos_reg == POS_LEN_LO) begin
                    len_next[7:0] = item.data;
                end else if (pos_reg == POS_LEN_HI) begin
                    len_next[15:8] = item.data;
                end else if (pos_reg == POS_TYPE) begin
                    type_next = item.data;
                end else if (pos_reg >= POS_CMD_FIRST && pos_reg <= POS_CMD_LAST) begin
                    cmd_next[pos_reg[1:0]] = item.data;
                end else if (pos_reg >= POS_ADDR_FIRST && pos_reg <= POS_ADDR_LAST) begin
                    addr_next[pos_reg[2:0]] = item.data;
                end else if (pos_reg == POS_SECOND_START) begin
                    second_ok_next = (item.data == HEAD_MARK);
                end
                sum_next  = sum_reg + prev_reg;
                prev_next = item.data;
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + 17'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            head_ok_reg   <= 1'b0;
            second_ok_reg <= 1'b0;
            len_reg       <= '0;
            type_reg      <= '0;
            cmd_reg       <= '0;
            addr_reg      <= '0;
        end else begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            prev_reg      <= prev_next;
            head_ok_reg   <= head_ok_next;
            second_ok_reg <= second_ok_next;
            len_reg       <= len_next;
            type_reg      <= type_next;
            cmd_reg       <= cmd_next;
            addr_reg      <= addr_next;
        end
    end

    `FCFE_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, step && item.last,
        pos_reg == '0 && sum_reg == '0 && len_reg == '0, "state not cleared after final byte")
    `FCFE_ASSERT_NEXT(a_pos_advance, aclk, aresetn, step && !item.last && pos_reg != POS_MAX,
        pos_reg == $past(pos_reg) + 17'd1, "byte position did not advance")

endmodule

/* sv/frame_check_and_field_extract_top.sv */
// Frame checker and header field extractor for a byte-serial message.
// Input: one message byte per s_ transfer, starting at the 0x68 head byte;
// s_tlast marks the final byte. Output: one record per m_ transfer.
// A byte at payload offsets 19 .. 19+L-1 (L from bytes 1..2) gives a payload
// record (m_tuser low) with the byte and its index. The final byte gives an
// end record (m_tuser high) with a check status; header fields are filled in
// only when the status is ok. Other bytes give no record.
// Path: a byte accepted at a rising edge lands in the input register, and
// its record is then loaded into the output register, which drives
// m_tvalid; a record held in the output register can delay that load.
// Throughput: one byte per cycle while no held record blocks the output,
// set by the single pass from input register to output register.
// Reset (aresetn low, synchronous) empties both registers and clears the
// message state to the start of a new message.
// When the receiver stalls, the held record waits in the output register;
// bytes that give no record keep flowing, and s_tready drops once a byte
// with a record is waiting behind the held one.
`include "assert_macros.svh"

module frame_check_and_field_extract_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                    // [26:24] check_status, [29:27] frame_type,
                                    // [30] status_flag, [31] ack_flag,
                                    // [63:32] command_word, [111:64] device_address,
                                    // [127:112] payload_length
    output logic         m_tuser    // record_kind
);
    import fcfe_pkg::*;

    logic         in_valid_reg,  in_valid_next;
    fcfe_item_t   in_item_reg,   in_item_next;
    logic         out_valid_reg, out_valid_next;
    fcfe_result_t out_rec_reg,   out_rec_next;

    logic         s_accept;
    logic         advance;
    logic         has_result;
    fcfe_result_t result;

    // Move the held byte on when its record has room or it makes none
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !has_result);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    fcfe_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .has_result (has_result),
        .result     (result)
    );

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
            in_item_next  = '{last: s_tlast, data: s_tdata};
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        if (advance && has_result) begin
            out_valid_next = 1'b1;
            out_rec_next   = result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_rec_reg <= out_rec_next;
    end

    // Pack the record onto the output channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rec_reg.kind;
    assign m_tdata  = {out_rec_reg.payload_length,
                       out_rec_reg.device_address,
                       out_rec_reg.command_word,
                       out_rec_reg.ack_flag,
                       out_rec_reg.status_flag,
                       out_rec_reg.frame_type,
                       out_rec_reg.check_status,
                       out_rec_reg.payload_index,
                       out_rec_reg.payload_byte};

    `FCFE_ASSERT_IMPL(a_fail_no_fields, aclk, aresetn,
        out_valid_reg && out_rec_reg.kind == REC_END && out_rec_reg.check_status != ST_OK,
        out_rec_reg.command_word == '0 && out_rec_reg.device_address == '0
            && out_rec_reg.payload_length == '0, "failed message carries header fields")
    `FCFE_ASSERT_IMPL(a_payload_clean, aclk, aresetn,
        out_valid_reg && out_rec_reg.kind == REC_PAYLOAD,
        out_rec_reg.check_status == ST_OK && out_rec_reg.command_word == '0,
        "payload record carries end-record fields")
    `FCFE_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready && has_result,
        "input stalled without a blocked record")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import fcfe_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // Ways to spoil a frame when building it
    typedef enum int {
        FLAW_NONE,
        FLAW_HEAD,
        FLAW_TAIL,
        FLAW_LENGTH,
        FLAW_SECOND,
        FLAW_SUM,
        FLAW_CUT,
        FLAW_EXTRA,
        FLAW_NOISE
    } flaw_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;

    // Header capture and checksum state of the frame being received
    pos_t        frame_pos;
    logic [7:0]  sum_acc;
    logic [7:0]  prior_byte;
    logic        head_seen;
    logic        second_seen;
    logic [15:0] len_field;
    logic [7:0]  type_field;
    logic [31:0] cmd_field;
    logic [47:0] addr_field;

    fcfe_result_t pending_records[$];

    int mismatches = 0;
    int bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    frame_check_and_field_extract_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Bound the run
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_frame();
        frame_pos   = '0;
        sum_acc     = 8'h00;
        prior_byte  = 8'h00;
        head_seen   = 1'b0;
        second_seen = 1'b0;
        len_field   = 16'h0000;
        type_field  = 8'h00;
        cmd_field   = 32'h0;
        addr_field  = 48'h0;
    endfunction

    // Work out the record, if any, that one accepted byte causes
    function automatic void predict_record(input logic [7:0] b, input logic last);
        fcfe_result_t rec;
        logic [17:0]  n;
        rec = '0;
        if (last) begin
            n = {1'b0, frame_pos} + 18'd1;
            rec.kind = REC_END;
            if (n < MIN_LEN)
                rec.check_status = ST_SHORT;
            else if (!head_seen || b != TAIL_MARK)
                rec.check_status = ST_HEAD_TAIL;
            else if ({2'b00, len_field} + MIN_LEN != n)
                rec.check_status = ST_LENGTH;
            else if (!second_seen)
                rec.check_status = ST_SECOND_START;
            else if (sum_acc != prior_byte)
                rec.check_status = ST_CHECKSUM;
            else
                rec.check_status = ST_OK;
            if (rec.check_status == ST_OK) begin
                rec.frame_type     = type_field[2:0];
                rec.status_flag    = type_field[6];
                rec.ack_flag       = type_field[7];
                rec.command_word   = cmd_field;
                rec.device_address = addr_field;
                rec.payload_length = len_field;
            end
            pending_records.push_back(rec);
            clear_frame();
            return;
        end

        // Capture header fields by position
        if (frame_pos == '0)
            head_seen = (b == HEAD_MARK);
        else if (frame_pos == POS_LEN_LO)
            len_field[7:0] = b;
        else if (frame_pos == POS_LEN_HI)
            len_field[15:8] = b;
        else if (frame_pos == POS_TYPE)
            type_field = b;
        else if (frame_pos >= POS_CMD_FIRST && frame_pos <= POS_CMD_LAST)
            cmd_field[8 * (frame_pos - POS_CMD_FIRST) +: 8] = b;
        else if (frame_pos >= POS_ADDR_FIRST && frame_pos <= POS_ADDR_LAST)
            addr_field[8 * (frame_pos - POS_ADDR_FIRST) +: 8] = b;
        else if (frame_pos == POS_SECOND_START)
            second_seen = (b == HEAD_MARK);

        // The sum trails by one byte so the checksum byte itself stays out
        sum_acc    = sum_acc + prior_byte;
        prior_byte = b;

        if (frame_pos >= PAYLOAD_START && frame_pos - PAYLOAD_START < {1'b0, len_field}) begin
            rec.kind          = REC_PAYLOAD;
            rec.payload_byte  = b;
            rec.payload_index = 16'(frame_pos - PAYLOAD_START);
            pending_records.push_back(rec);
        end
        if (frame_pos != POS_MAX)
            frame_pos = frame_pos + 17'd1;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    // Compare each output transfer with the oldest expected record
    always @(posedge aclk) begin
        fcfe_result_t want;
        fcfe_result_t got;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.kind           = record_kind_t'(m_tuser);
            got.payload_byte   = m_tdata[7:0];
            got.payload_index  = m_tdata[23:8];
            got.check_status   = check_status_t'(m_tdata[26:24]);
            got.frame_type     = m_tdata[29:27];
            got.status_flag    = m_tdata[30];
            got.ack_flag       = m_tdata[31];
            got.command_word   = m_tdata[63:32];
            got.device_address = m_tdata[111:64];
            got.payload_length = m_tdata[127:112];
            if (pending_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("record with none expected: tuser %0b tdata %0h",
                             m_tuser, m_tdata);
            end else begin
                want = pending_records.pop_front();
                check_field("record_kind", want.kind, got.kind);
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("payload_index", want.payload_index, got.payload_index);
                check_field("check_status", want.check_status, got.check_status);
                check_field("frame_type", want.frame_type, got.frame_type);
                check_field("status_flag", want.status_flag, got.status_flag);
                check_field("ack_flag", want.ack_flag, got.ack_flag);
                check_field("command_word", want.command_word, got.command_word);
                check_field("device_address", want.device_address, got.device_address);
                check_field("payload_length", want.payload_length, got.payload_length);
            end
        end
    end

    // Drive the receiver: a long hold-off takes priority over random stalls
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and wait for the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_record(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_q_t q);
        foreach (q[k])
            send_byte(q[k], k == q.size() - 1);
    endtask

    // Drop valid and hold until every expected record has come
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // Build a frame; amount is the kept length for a cut, the surplus byte count, or the noise length
    function automatic byte_q_t build_frame(input logic [15:0] len, input logic [7:0] kind_byte,
                                            input logic [31:0] cmd, input logic [47:0] addr,
                                            input flaw_t flaw, input int amount);
        byte_q_t    q;
        logic [7:0] sum;
        int         i;
        q = {};
        if (flaw == FLAW_NOISE) begin
            repeat (amount) q.push_back(8'($urandom));
            return q;
        end
        q.push_back(HEAD_MARK);
        q.push_back(len[7:0]);
        q.push_back(len[15:8]);
        q.push_back(kind_byte);
        for (i = 0; i < 4; i++)
            q.push_back(cmd[8 * i +: 8]);
        for (i = 0; i < 6; i++)
            q.push_back(addr[8 * i +: 8]);
        repeat (4) q.push_back(8'($urandom));
        q.push_back(HEAD_MARK);
        for (i = 0; i < len; i++)
            q.push_back(8'($urandom));
        if (flaw == FLAW_EXTRA)
            repeat (amount) q.push_back(8'($urandom));
        if (flaw == FLAW_HEAD)
            q[0] = HEAD_MARK ^ 8'($urandom_range(255, 1));
        if (flaw == FLAW_SECOND)
            q[18] = HEAD_MARK ^ 8'($urandom_range(255, 1));
        if (flaw == FLAW_LENGTH)
            q[$urandom_range(2, 1)] ^= 8'($urandom_range(255, 1));
        sum = 8'h00;
        foreach (q[k])
            sum = sum + q[k];
        q.push_back(flaw == FLAW_SUM ? sum ^ 8'($urandom_range(255, 1)) : sum);
        q.push_back(flaw == FLAW_TAIL ? TAIL_MARK ^ 8'($urandom_range(255, 1)) : TAIL_MARK);
        if (flaw == FLAW_CUT)
            while (q.size() > amount)
                void'(q.pop_back());
        return q;
    endfunction

    task automatic send_random_frame();
        flaw_t       flaw;
        logic [15:0] len;
        int          amount;
        len = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(200, 25))
                                          : 16'($urandom_range(24, 0));
        flaw = ($urandom_range(99, 0) < 70) ? FLAW_NONE
                                            : flaw_t'($urandom_range(FLAW_NOISE, FLAW_HEAD));
        case (flaw)
            FLAW_CUT:   amount = $urandom_range(len + 20, 1);
            FLAW_EXTRA: amount = $urandom_range(8, 1);
            FLAW_NOISE: amount = $urandom_range(40, 1);
            default:    amount = 0;
        endcase
        send_frame(build_frame(len, 8'($urandom), $urandom, {16'($urandom), 32'($urandom)},
                               flaw, amount));
    endtask

    // Each check status, the field extremes and the odd frame shapes
    task automatic test_status_codes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_frame(build_frame(16'd0, 8'h00, 32'h0, 48'h0, FLAW_NONE, 0));
        send_frame(build_frame(16'd3, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, FLAW_NONE, 0));
        send_frame(build_frame(16'd4, 8'h45, 32'h8001_7F10, 48'hA5A5_0102_0304, FLAW_NONE, 0));
        send_frame(build_frame(16'd2, 8'h12, 32'h1, 48'h1, FLAW_CUT, 1));
        send_frame(build_frame(16'd2, 8'h12, 32'h1, 48'h1, FLAW_CUT, 20));
        send_frame(build_frame(16'd1, 8'h81, 32'h2, 48'h2, FLAW_HEAD, 0));
        send_frame(build_frame(16'd1, 8'h81, 32'h2, 48'h2, FLAW_TAIL, 0));
        send_frame(build_frame(16'd1, 8'h81, 32'h2, 48'h2, FLAW_LENGTH, 0));
        send_frame(build_frame(16'd1, 8'h81, 32'h2, 48'h2, FLAW_SECOND, 0));
        send_frame(build_frame(16'd1, 8'h81, 32'h2, 48'h2, FLAW_SUM, 0));
        // Last byte lands inside the payload window
        send_frame(build_frame(16'd10, 8'h03, 32'h3, 48'h3, FLAW_CUT, 25));
        // Surplus bytes past the payload give no records
        send_frame(build_frame(16'd2, 8'h03, 32'h3, 48'h3, FLAW_EXTRA, 3));
        drain();
    endtask

    // Largest length field, with the message ending inside the payload window
    task automatic test_max_length_field();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_frame(build_frame(16'hFFFF, 8'hC7, $urandom, 48'h0, FLAW_CUT, 80));
        drain();
    endtask

    // Hold the receiver off while bytes keep coming, then pause for the drain
    task automatic test_receiver_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 150;
        send_frame(build_frame(16'd45, 8'h42, $urandom, 48'h1234_5678_9ABC, FLAW_NONE, 0));
        send_frame(build_frame(16'd5, 8'h01, $urandom, 48'h0, FLAW_NONE, 0));
        drain();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int quota);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < quota)
            send_random_frame();
        drain();
    endtask

    initial begin
        clear_frame();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_status_codes();
        test_receiver_holdoff();
        test_random_traffic(0, 0, 330);
        test_random_traffic(81, 0, 330);
        test_random_traffic(0, 81, 330);
        test_random_traffic(8, 8, 330);
        test_max_length_field();

        // Let any stray record show up
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* frame_check_and_field_extract_top.f */
+incdir+sv
sv/fcfe_pkg.sv
sv/fcfe_core.sv
sv/frame_check_and_field_extract_top.sv
sim/testbench.sv
